FILE: hdl/ndv_pkg.sv
// Package: shared types and constants of the noise drum voice.
`default_nettype none
package ndv_pkg;

   localparam int WORDS_PER_SEG = 9;

   // input functions
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_START  = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // segment word selects
   localparam logic [3:0] W_DUR    = 4'd0;
   localparam logic [3:0] W_TONE   = 4'd1;
   localparam logic [3:0] W_TSWEEP = 4'd2;
   localparam logic [3:0] W_MIX    = 4'd3;
   localparam logic [3:0] W_LEVEL  = 4'd4;
   localparam logic [3:0] W_ENV    = 4'd5;
   localparam logic [3:0] W_NPER   = 4'd6;
   localparam logic [3:0] W_NSWP   = 4'd7;
   localparam logic [3:0] W_NSTEP  = 4'd8;

   localparam logic [15:0] SEED_ADD = 16'h3711;
   localparam logic [4:0]  LEVEL_MAX = 5'd16;

   // play phases
   typedef enum logic [1:0] {
      PH_INIT    = 2'd0,
      PH_PLAY    = 2'd1,
      PH_IDLE    = 2'd2,
      PH_PENDING = 2'd3
   } phase_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_TICK0,
      S_RD_TONE,
      S_RD_NPER,
      S_RD_MIX,
      S_RD_TSWEEP,
      S_TONE,
      S_RD_NSWP,
      S_RD_NSTEP,
      S_NOISE,
      S_RD_ENV,
      S_RD_LEVEL,
      S_RD_DUR,
      S_FINISH,
      S_MUL,
      S_DIV,
      S_VOL,
      S_OUT
   } state_type;

   function automatic logic [7:0] level_map(input logic [4:0] lv);
      logic [7:0] r;
      case (lv)
         5'd0:  r = 8'd0;
         5'd1:  r = 8'd10;
         5'd2:  r = 8'd12;
         5'd3:  r = 8'd16;
         5'd4:  r = 8'd20;
         5'd5:  r = 8'd25;
         5'd6:  r = 8'd32;
         5'd7:  r = 8'd40;
         5'd8:  r = 8'd51;
         5'd9:  r = 8'd64;
         5'd10: r = 8'd80;
         5'd11: r = 8'd101;
         5'd12: r = 8'd128;
         5'd13: r = 8'd161;
         5'd14: r = 8'd203;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/ndv_if.sv
// Interfaces: valid/ready channels for requests, responses and the register write.
`default_nettype none
interface ndv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [4:0]  slot;
   logic [3:0]  field_select;
   logic [23:0] value;
   logic [2:0]  segment_count;
   modport source (output valid, func, slot, field_select, value, segment_count,
                   input ready);
   modport sink (input valid, func, slot, field_select, value, segment_count,
                 output ready);
endinterface

interface ndv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   modport source (output valid, sample, input ready);
   modport sink (input valid, sample, output ready);
endinterface

interface ndv_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ndv_div.sv
// Restoring divider: 38-bit dividend by 24-bit divisor, one quotient bit a cycle.
`default_nettype none
module ndv_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [37:0] dividend,
   input  wire logic [23:0] divisor,
   output logic             done,
   output logic [37:0]      quotient
);
   logic [37:0] quo_ff, quo_in;
   logic [23:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [24:0] trial;
   logic [25:0] diff;

   // one shift-subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[37]};
      diff    = {1'b0, trial} - {2'b0, divisor};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd38;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[25]) begin
            rem_in = diff[23:0];
            quo_in = {quo_ff[36:0], 1'b1};
         end else begin
            rem_in = trial[23:0];
            quo_in = {quo_ff[36:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd1);
   assign quotient = quo_in;
endmodule
`default_nettype wire

FILE: hdl/noise_drum_voice_top.sv
// Top level: noise drum voice sequencer, segment memory and shared datapath.
// One transaction in, at most one sample out. A load passes through the write
// state before the block is ready again; a start is taken in the idle state. A tick
// reads its segment words one per cycle from the read port of the segment memory;
// the path to a valid sample is shortest when idle, then longer in the low tone
// phase, when the noise gate is off, without envelope or at envelope end, when an
// envelope-free segment moves on, and longest when the envelope runs the divide by
// the envelope length. The block is not ready while an item is in work or a sample
// waits to be taken.
`default_nettype none
module noise_drum_voice_top import ndv_pkg::*; #(
   parameter int SEGMENT_SLOTS = 32,
   parameter int TICK_STEP     = 1000,
   parameter int FRAME_STEP    = 16667
) (
   input wire logic clock,
   input wire logic reset,
   ndv_req_if.sink   req,
   ndv_rsp_if.source rsp,
   ndv_csr_if.sink   csr
);
   localparam int DEPTH = SEGMENT_SLOTS * WORDS_PER_SEG;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
   localparam logic [31:0] TSTEP = 32'(TICK_STEP);
   localparam logic [31:0] FSTEP = 32'(FRAME_STEP);

   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;

   state_type st_ff, st_in;
   phase_type phase_ff, phase_in;
   logic [4:0]  mvol_ff, mvol_in;
   logic [4:0]  pstart_ff, pstart_in, astart_ff, astart_in;
   logic [2:0]  pcnt_ff, pcnt_in, acnt_ff, acnt_in;
   logic [1:0]  segidx_ff, segidx_in;
   logic [31:0] tper_ff, tper_in, thalf_ff, thalf_in, tcnt_ff, tcnt_in;
   logic [31:0] tswc_ff, tswc_in, nper_ff, nper_in, ncnt_ff, ncnt_in;
   logic [31:0] nswc_ff, nswc_in, rel_ff, rel_in;
   logic        nhold_ff, nhold_in;
   logic [15:0] seed_ff, seed_in;
   logic [4:0]  slot_ff, slot_in;
   logic [3:0]  sel_ff, sel_in;
   logic [23:0] val_ff, val_in;
   logic [23:0] mix_ff, mix_in, env_ff, env_in, aux_ff, aux_in;
   logic        bit_ff, bit_in;
   logic [4:0]  lvl_ff, lvl_in;
   logic [37:0] prod_ff, prod_in;
   logic        rv_ff, rv_in;
   logic [7:0]  smp_ff, smp_in;
   logic [3:0]  rd_sel;
   logic        div_start, div_done;
   logic [37:0] div_q;
   logic [5:0]  seg_sum;
   logic [SW-1:0] seg_slot;
   logic [SW-1:0] slot_tab [64];
   logic [31:0] sum;
   logic [15:0] seed_nx;
   logic [9:0]  vol_prod;
   logic [4:0]  lv_sub;

   // segment memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= val_ff;
      rd_data <= mem[rd_addr];
   end

   // program slot wrap: constant table over start slot plus segment index
   for (genvar g = 0; g < 64; g++) begin : g_slot
      assign slot_tab[g] = SW'(g % SEGMENT_SLOTS);
   end

   assign seg_sum  = 6'(astart_ff) + 6'(segidx_ff);
   assign seg_slot = slot_tab[seg_sum];
   assign rd_addr  = AW'(seg_slot * WORDS_PER_SEG + 32'(rd_sel));
   assign wr_addr  = AW'(32'(slot_ff) * WORDS_PER_SEG + 32'(sel_ff));

   ndv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (env_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req.ready  = (st_ff == S_IDLE) && !rv_ff;
   assign csr.ready  = 1'b1;
   assign rsp.valid  = rv_ff;
   assign rsp.sample = smp_ff;
   assign seed_nx    = 16'(seed_ff * 16'd5) + SEED_ADD;
   assign vol_prod   = 10'(lvl_ff) * 10'(mvol_ff);

   // sequencer and shared datapath
   always_comb begin
      st_in = st_ff; phase_in = phase_ff; mvol_in = mvol_ff;
      pstart_in = pstart_ff; pcnt_in = pcnt_ff; astart_in = astart_ff;
      acnt_in = acnt_ff; segidx_in = segidx_ff;
      tper_in = tper_ff; thalf_in = thalf_ff; tcnt_in = tcnt_ff; tswc_in = tswc_ff;
      nper_in = nper_ff; ncnt_in = ncnt_ff; nswc_in = nswc_ff; rel_in = rel_ff;
      nhold_in = nhold_ff; seed_in = seed_ff;
      slot_in = slot_ff; sel_in = sel_ff; val_in = val_ff;
      mix_in = mix_ff; env_in = env_ff; aux_in = aux_ff;
      bit_in = bit_ff; lvl_in = lvl_ff; prod_in = prod_ff;
      rv_in = rv_ff; smp_in = smp_ff;
      rd_sel = W_DUR; wr_en = 1'b0; div_start = 1'b0;
      sum = '0; lv_sub = '0;

      if (rsp.valid && rsp.ready) rv_in = 1'b0;
      if (csr.valid) mvol_in = (csr.data > LEVEL_MAX) ? LEVEL_MAX : csr.data;

      case (st_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               slot_in = req.slot; sel_in = req.field_select;
               val_in = req.value;
               case (req.func)
                  FUNC_LOAD:  st_in = S_LOAD;
                  FUNC_START: begin
                     pstart_in = req.slot;
                     pcnt_in = (req.segment_count == 3'd0) ? 3'd1 :
                               (req.segment_count > 3'd4) ? 3'd4 : req.segment_count;
                     phase_in = PH_PENDING;
                  end
                  FUNC_TICK:  st_in = S_TICK0;
                  default: ;
               endcase
            end
         end
         S_LOAD: begin
            wr_en = (sel_ff <= W_NSTEP) && (32'(slot_ff) < 32'(SEGMENT_SLOTS));
            st_in = S_IDLE;
         end
         S_TICK0: begin
            if (phase_ff == PH_IDLE) begin
               smp_in = 8'd0; st_in = S_OUT;
            end else begin
               if (phase_ff == PH_PENDING) begin
                  astart_in = pstart_ff; acnt_in = pcnt_ff; segidx_in = 2'd0;
                  phase_in = PH_INIT;
               end
               st_in = S_RD_TONE;
            end
         end
         // issue tone period read
         S_RD_TONE: begin
            rd_sel = W_TONE; st_in = S_RD_NPER;
         end
         S_RD_NPER: begin
            rd_sel = W_NPER;
            if (phase_ff == PH_INIT) begin
               tper_in = 32'(rd_data); thalf_in = 32'(rd_data[23:1]);
            end
            st_in = S_RD_MIX;
         end
         S_RD_MIX: begin
            rd_sel = W_MIX;
            if (phase_ff == PH_INIT) begin
               nper_in = 32'(rd_data); rel_in = '0; tswc_in = '0; nswc_in = '0;
               phase_in = PH_PLAY;
            end
            st_in = S_RD_TSWEEP;
         end
         S_RD_TSWEEP: begin
            rd_sel = W_TSWEEP;
            rel_in = rel_ff + TSTEP;
            mix_in = rd_data;
            bit_in = 1'b0;
            st_in = S_TONE;
         end
         // tone sweep and phase
         S_TONE: begin
            rd_sel = W_NSWP;
            if (mix_ff[0]) begin
               st_in = S_RD_NSTEP;
            end else begin
               sum = tswc_ff + TSTEP;
               tswc_in = sum;
               if (rd_data != 24'd0 && sum > FSTEP) begin
                  tper_in = tper_ff + 32'(rd_data);
                  thalf_in = tper_in >> 1;
                  tswc_in = sum - FSTEP;
               end
               tcnt_in = tcnt_ff + TSTEP;
               if (tcnt_in < thalf_in) begin
                  bit_in = 1'b1; st_in = S_RD_NSTEP;
               end else if (tcnt_in > tper_in) begin
                  tcnt_in = tcnt_in - tper_in; bit_in = 1'b1; st_in = S_RD_NSTEP;
               end else begin
                  smp_in = 8'd0; st_in = S_OUT;
               end
            end
         end
         S_RD_NSTEP: begin
            rd_sel = W_NSTEP;
            aux_in = rd_data;
            st_in = S_RD_NSWP;
         end
         S_RD_NSWP: begin
            rd_sel = W_ENV;
            if (!mix_ff[3]) begin
               sum = nswc_ff + TSTEP;
               nswc_in = sum;
               if (aux_ff != 24'd0 && sum > 32'(aux_ff)) begin
                  nper_in = nper_ff + 32'(rd_data);
                  nswc_in = sum - 32'(aux_ff);
               end
            end
            st_in = S_NOISE;
         end
         // noise generator and hold; rd_data is envelope
         S_NOISE: begin
            rd_sel = W_LEVEL;
            env_in = rd_data;
            if (!mix_ff[3]) begin
               ncnt_in = ncnt_ff + TSTEP;
               if (ncnt_in >= nper_ff) begin
                  seed_in = seed_nx;
                  bit_in = (seed_nx[15:8] < 8'd128) ? 1'b0 :
                           ((rd_data == 24'd0) ? 1'b1 : (rel_ff < 32'(rd_data)));
                  nhold_in = bit_in;
                  ncnt_in = ncnt_in - nper_ff;
               end else begin
                  bit_in = nhold_ff;
               end
            end
            st_in = S_RD_LEVEL;
         end
         // rd_data is level
         S_RD_LEVEL: begin
            rd_sel = W_DUR;
            lvl_in = (rd_data > 24'(LEVEL_MAX)) ? LEVEL_MAX : rd_data[4:0];
            if (!bit_ff) begin
               smp_in = 8'd0; st_in = S_OUT;
            end else begin
               st_in = S_RD_DUR;
            end
         end
         S_RD_DUR: begin
            rd_sel = W_DUR;
            st_in = S_FINISH;
         end
         // envelope decision; rd_data is duration
         S_FINISH: begin
            if (env_ff == 24'd0) begin
               smp_in = level_map(lvl_ff);
               if (rel_ff > 32'(rd_data)) begin
                  if (3'(segidx_ff) + 3'd1 < acnt_ff) begin
                     segidx_in = segidx_ff + 2'd1; phase_in = PH_INIT;
                     // level of the new segment
                     st_in = S_MUL;
                  end else begin
                     phase_in = PH_IDLE; st_in = S_OUT;
                  end
               end else begin
                  st_in = S_OUT;
               end
            end else if (rel_ff > 32'(env_ff)) begin
               if (3'(segidx_ff) + 3'd1 < acnt_ff) begin
                  segidx_in = segidx_ff + 2'd1; phase_in = PH_INIT;
               end else begin
                  phase_in = PH_IDLE;
               end
               smp_in = 8'd0; st_in = S_OUT;
            end else begin
               // release_count <= env < 2^24, product fits 29 bits
               prod_in = 38'(lvl_ff) * 38'(rel_ff[23:0]);
               div_start = 1'b0;
               st_in = S_MUL;
            end
         end
         // envelope 0 after advance: reread level; otherwise start divide
         S_MUL: begin
            rd_sel = W_LEVEL;
            if (env_ff == 24'd0) begin
               st_in = S_VOL;
            end else begin
               div_start = 1'b1; st_in = S_DIV;
            end
         end
         S_DIV: begin
            rd_sel = W_LEVEL;
            if (div_done) begin
               lv_sub = lvl_ff - 5'(div_q);
               lvl_in = lv_sub;
               st_in = S_VOL;
            end
         end
         S_VOL: begin
            if (env_ff == 24'd0) begin
               smp_in = level_map((rd_data > 24'(LEVEL_MAX)) ? LEVEL_MAX : rd_data[4:0]);
            end else begin
               smp_in = level_map((vol_prod[9:4] > 6'd16) ? LEVEL_MAX : vol_prod[8:4]);
            end
            st_in = S_OUT;
         end
         S_OUT: begin
            rv_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; phase_ff <= PH_IDLE; mvol_ff <= '0;
         pstart_ff <= '0; pcnt_ff <= '0; astart_ff <= '0; acnt_ff <= '0;
         segidx_ff <= '0; tper_ff <= '0; thalf_ff <= '0; tcnt_ff <= '0;
         tswc_ff <= '0; nper_ff <= '0; ncnt_ff <= '0; nswc_ff <= '0; rel_ff <= '0;
         nhold_ff <= 1'b0; seed_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; phase_ff <= phase_in; mvol_ff <= mvol_in;
         pstart_ff <= pstart_in; pcnt_ff <= pcnt_in; astart_ff <= astart_in;
         acnt_ff <= acnt_in; segidx_ff <= segidx_in;
         tper_ff <= tper_in; thalf_ff <= thalf_in; tcnt_ff <= tcnt_in;
         tswc_ff <= tswc_in; nper_ff <= nper_in; ncnt_ff <= ncnt_in;
         nswc_ff <= nswc_in; rel_ff <= rel_in;
         nhold_ff <= nhold_in; seed_ff <= seed_in; rv_ff <= rv_in;
      end
      slot_ff <= slot_in; sel_ff <= sel_in; val_ff <= val_in;
      mix_ff <= mix_in; env_ff <= env_in; aux_ff <= aux_in;
      bit_ff <= bit_in; lvl_ff <= lvl_in; prod_ff <= prod_in; smp_ff <= smp_in;
   end
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the noise drum voice: directed and random transactions, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class sample_board;
   // voice state
   logic [23:0] seg_mem [0:287];
   bit [4:0]  volume;
   bit [1:0]  phase;
   bit [4:0]  pend_start, act_start;
   bit [2:0]  pend_count, act_count;
   bit [1:0]  seg_idx;
   bit [31:0] tone_per, tone_half, tone_cnt, tone_swp_cnt;
   bit [31:0] noise_per, noise_cnt, noise_swp_cnt, rel_cnt;
   bit        hold;
   bit [15:0] seed;
   bit [7:0]  pending_samples[$];
   int        errors;
   int        checked;

   function new();
      foreach (seg_mem[i]) seg_mem[i] = '0;
      phase = ndv_pkg::PH_IDLE;
   endfunction

   function void set_volume(bit [4:0] v);
      volume = (v > 16) ? 5'd16 : v;
   endfunction

   function bit [31:0] word(bit [3:0] w);
      int s;
      s = (act_start + seg_idx) % 32;
      return {8'd0, seg_mem[s * 9 + w]};
   endfunction

   function bit [7:0] lmap(bit [31:0] lv);
      bit [7:0] t[17] = '{0, 10, 12, 16, 20, 25, 32, 40, 51, 64, 80, 101, 128, 161,
                          203, 255, 255};
      return t[lv];
   endfunction

   function void next_seg();
      if (seg_idx + 1 < act_count) begin
         seg_idx = 2'(seg_idx + 1);
         phase = ndv_pkg::PH_INIT;
      end else begin
         phase = ndv_pkg::PH_IDLE;
      end
   endfunction

   function bit [7:0] run_tick();
      bit        b;
      bit [31:0] mix, env, lv, sw, sp, gate;
      bit [63:0] prod;
      b = 0;
      if (phase == ndv_pkg::PH_IDLE) return 0;
      if (phase == ndv_pkg::PH_PENDING) begin
         act_start = pend_start;
         act_count = pend_count;
         seg_idx = 0;
         phase = ndv_pkg::PH_INIT;
      end
      if (phase == ndv_pkg::PH_INIT) begin
         tone_per = word(ndv_pkg::W_TONE);
         tone_half = tone_per >> 1;
         noise_per = word(ndv_pkg::W_NPER);
         rel_cnt = 0;
         tone_swp_cnt = 0;
         noise_swp_cnt = 0;
         phase = ndv_pkg::PH_PLAY;
      end
      rel_cnt += 1000;
      mix = word(ndv_pkg::W_MIX);
      if (mix[0] == 0) begin
         sw = word(ndv_pkg::W_TSWEEP);
         tone_swp_cnt += 1000;
         if (sw > 0 && tone_swp_cnt > 16667) begin
            tone_per += sw;
            tone_half = tone_per >> 1;
            tone_swp_cnt -= 16667;
         end
         tone_cnt += 1000;
         if (tone_cnt < tone_half) b = 1;
         else if (tone_cnt > tone_per) begin
            tone_cnt -= tone_per;
            b = 1;
         end else return 0;
      end
      if (mix[3] == 0) begin
         sp = word(ndv_pkg::W_NSWP);
         noise_swp_cnt += 1000;
         if (sp > 0 && noise_swp_cnt > sp) begin
            noise_per += word(ndv_pkg::W_NSTEP);
            noise_swp_cnt -= sp;
         end
         noise_cnt += 1000;
         if (noise_cnt >= noise_per) begin
            env = word(ndv_pkg::W_ENV);
            gate = (env > 0) ? 32'(rel_cnt < env) : 32'd1;
            seed = seed * 16'd5 + ndv_pkg::SEED_ADD;
            b = (seed[15:8] < 128) ? 1'b0 : gate[0];
            hold = b;
            noise_cnt -= noise_per;
         end else b = hold;
      end
      if (!b) return 0;
      env = word(ndv_pkg::W_ENV);
      if (env == 0) begin
         if (rel_cnt > word(ndv_pkg::W_DUR)) next_seg();
         lv = word(ndv_pkg::W_LEVEL);
         return lmap(lv > 16 ? 32'd16 : lv);
      end
      if (rel_cnt > env) begin
         next_seg();
         return 0;
      end
      lv = word(ndv_pkg::W_LEVEL);
      if (lv > 16) lv = 16;
      prod = 64'(lv) * 64'(rel_cnt);
      lv = lv - 32'(prod / 64'(env));
      lv = (lv * volume) / 16;
      if (lv > 16) lv = 16;
      return lmap(lv);
   endfunction

   // note an accepted request
   function void note_request(bit [1:0] f, bit [4:0] s, bit [3:0] fs, bit [23:0] v,
                              bit [2:0] c);
      case (f)
         ndv_pkg::FUNC_LOAD: if (fs < 9) seg_mem[s * 9 + fs] = v;
         ndv_pkg::FUNC_START: begin
            pend_start = s;
            pend_count = (c == 0) ? 3'd1 : (c > 4 ? 3'd4 : c);
            phase = ndv_pkg::PH_PENDING;
         end
         ndv_pkg::FUNC_TICK: pending_samples.push_back(run_tick());
         default: ;
      endcase
   endfunction

   // check an accepted sample
   function void check_sample(bit [7:0] got);
      bit [7:0] exp_s;
      if (pending_samples.size() == 0) begin
         $error("sample: none expected, actual %0d", got);
         errors++;
         return;
      end
      exp_s = pending_samples.pop_front();
      checked++;
      if (got !== exp_s) begin
         $error("sample: expected %0d, actual %0d", exp_s, got);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import ndv_pkg::*;

   logic clock = 0;
   logic reset = 1;
   ndv_req_if req ();
   ndv_rsp_if rsp ();
   ndv_csr_if csr ();

   sample_board board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit recv_hold = 0;
   bit [4:0] written_slots[$];
   int n_ticks, n_loads, n_starts;

   noise_drum_voice_top dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   always #10 clock = ~clock;

   initial begin
      req.valid = 0; req.func = '0; req.slot = '0; req.field_select = '0;
      req.value = '0; req.segment_count = '0;
      rsp.ready = 0; csr.valid = 0; csr.data = '0;
   end

   // receiver: random stall, or held off entirely
   always @(posedge clock) begin
      if (rsp.valid && rsp.ready) board.check_sample(rsp.sample);
      rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // valid stays high after acceptance until the next transaction or an idle cycle
   task automatic send(bit [1:0] f, bit [4:0] s, bit [3:0] fs, bit [23:0] v, bit [2:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1; req.func <= f; req.slot <= s; req.field_select <= fs;
      req.value <= v; req.segment_count <= c;
      do @(posedge clock); while (!req.ready);
      board.note_request(f, s, fs, v, c);
      if (f == FUNC_TICK) n_ticks++;
      else if (f == FUNC_LOAD) n_loads++;
      else if (f == FUNC_START) n_starts++;
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending_samples.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_volume(bit [4:0] v);
      drain();
      csr.valid <= 1; csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      board.set_volume(v);
      csr.valid <= 0;
   endtask

   // segment with random but playable content
   task automatic load_segment(bit [4:0] s, bit full);
      bit [23:0] v;
      for (int w = 0; w < 9; w++) begin
         case (w)
            0: v = 24'(full ? $urandom : $urandom_range(20000));
            1: v = 24'(full ? $urandom : $urandom_range(8000));
            2: v = 24'($urandom_range(3) == 0 ? $urandom : $urandom_range(600));
            3: v = 24'($urandom_range(15) | ($urandom_range(15) == 0 ? $urandom : 0));
            4: v = 24'($urandom_range(7) == 0 ? $urandom : $urandom_range(16));
            5: v = 24'($urandom_range(3) == 0 ? 0 :
                       (full ? $urandom : $urandom_range(40000)));
            6: v = 24'(full ? $urandom : $urandom_range(5000));
            7: v = 24'($urandom_range(3) == 0 ? 0 : $urandom_range(9000));
            default: v = 24'(full ? $urandom : $urandom_range(900));
         endcase
         send(FUNC_LOAD, s, 4'(w), v, 3'($urandom));
      end
      if (!(s inside {written_slots})) written_slots.push_back(s);
   endtask

   function automatic bit [4:0] pick_start(output bit [2:0] c);
      bit [4:0] s;
      int n;
      // only programs whose segments are all written
      forever begin
         s = written_slots[$urandom_range(written_slots.size() - 1)];
         c = 3'($urandom);
         n = (c == 0) ? 1 : (c > 4 ? 4 : c);
         for (int k = 0; k < n; k++) if (!(5'(s + k) inside {written_slots})) n = -1;
         if (n > 0) return s;
      end
   endfunction

   task automatic random_phase(int items);
      bit [2:0] c;
      bit [4:0] s;
      int k;
      k = 0;
      while (k < items) begin
         case ($urandom_range(19))
            0: begin load_segment(5'($urandom), $urandom_range(4) == 0); k += 9; end
            1: begin
               s = pick_start(c);
               send(FUNC_START, s, 4'($urandom), 24'($urandom), c);
               k++;
            end
            2: begin
               send(FUNC_LOAD, 5'($urandom), 4'($urandom_range(9, 15)), 24'($urandom),
                    3'($urandom));
               k++;
            end
            3: send(FUNC_UNUSED, 5'($urandom), 4'($urandom), 24'($urandom), 3'($urandom));
            default: begin
               send(FUNC_TICK, 5'($urandom), 4'($urandom), 24'($urandom), 3'($urandom));
               k++;
            end
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: idle tick, extremes, every function, count edges
      write_volume(5'd31);
      send(FUNC_TICK, 5'd0, 4'd0, 24'd0, 3'd0);
      for (int s = 0; s < 5; s++) load_segment(5'(s), 1'b0);
      load_segment(5'd31, 1'b1);
      send(FUNC_LOAD, 5'd31, 4'd15, 24'hFFFFFF, 3'd7);
      send(FUNC_UNUSED, 5'd31, 4'd15, 24'hFFFFFF, 3'd7);
      send(FUNC_START, 5'd31, 4'd0, 24'd0, 3'd2); // wraps to slot 0
      repeat (6) send(FUNC_TICK, 5'd0, 4'd0, 24'd0, 3'd0);
      send(FUNC_START, 5'd0, 4'd0, 24'd0, 3'd0);
      repeat (4) send(FUNC_TICK, 5'd31, 4'd15, 24'hFFFFFF, 3'd7);
      send(FUNC_START, 5'd1, 4'd15, 24'hFFFFFF, 3'd7);
      repeat (4) send(FUNC_TICK, 5'd0, 4'd0, 24'd0, 3'd0);

      write_volume(5'd0);
      random_phase(150);
      write_volume(5'd16);
      send_idle_pct = 49;
      random_phase(150);
      write_volume(5'($urandom_range(1, 15)));
      send_idle_pct = 0; recv_stall_pct = 49;
      random_phase(150);
      write_volume(5'd8);
      send_idle_pct = 23; recv_stall_pct = 23;
      random_phase(150);

      // long receiver hold-off while ticks keep coming
      send_idle_pct = 0; recv_stall_pct = 0;
      fork
         begin recv_hold = 1; repeat (400) @(posedge clock); recv_hold = 0; end
         repeat (5) send(FUNC_TICK, 5'd0, 4'd0, 24'd0, 3'd0);
      join
      drain();
      random_phase(40);

      drain();
      $display("tb_top: %0d ticks (%0d samples checked), %0d loads, %0d starts, volume 0..31",
               n_ticks, board.checked, n_loads, n_starts);
      if (board.errors == 0 && board.pending_samples.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

FILE: noise_drum_voice_top.f
hdl/ndv_pkg.sv
hdl/ndv_if.sv
hdl/ndv_div.sv
hdl/noise_drum_voice_top.sv
sim/tb_top.sv
